FILE: hw/rtl/htpd_pkg.sv
package htpd_pkg;

	localparam int unsigned HdrBytes = 4;
	localparam int unsigned LenW = 11;
	localparam logic [LenW-1:0] SatLen = '1;

	localparam logic [31:0] HeaderWordRst = 32'h2A48_5954;
	localparam logic [7:0] TailByteRst = 8'h23;
	localparam logic [LenW-1:0] MaxPacketLenRst = 11'd256;
	localparam logic [LenW-1:0] RecvBufferLimitRst = 11'd1280;

	localparam logic [1:0] REG_HEADER_WORD = 2'd0;
	localparam logic [1:0] REG_TAIL_BYTE = 2'd1;
	localparam logic [1:0] REG_MAX_PACKET_LEN = 2'd2;
	localparam logic [1:0] REG_RECV_BUFFER_LIMIT = 2'd3;

	localparam logic [2:0] EV_DROPPED = 3'd0;
	localparam logic [2:0] EV_PACKET_BYTE = 3'd1;
	localparam logic [2:0] EV_GOOD_END = 3'd2;
	localparam logic [2:0] EV_TOO_LONG_END = 3'd3;
	localparam logic [2:0] EV_HEADER_ABORT = 3'd4;
	localparam logic [2:0] EV_OVERLENGTH_ABORT = 3'd5;
	localparam logic [2:0] EV_OVERFLOW_ABORT = 3'd6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic chunk_first;
		logic chunk_last;
		logic [15:0] chunk_length;
		logic [15:0] conn_id;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [15:0] out_conn_id;
		logic [2:0] event_res;
		logic [LenW-1:0] packet_length;
	} out_item_t;

	typedef struct packed {
		logic [31:0] header_word;
		logic [7:0] tail_byte;
		logic [LenW-1:0] max_packet_len;
		logic [LenW-1:0] recv_buffer_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0] header_index;
		logic header_bad;
		logic [LenW-1:0] pending_count;
		logic dropping_chunk;
	} frm_state_t;

endpackage

FILE: hw/rtl/htpd_step.sv
module htpd_step (
	input htpd_pkg::cfg_t cfg,
	input htpd_pkg::frm_state_t cur,
	input htpd_pkg::in_item_t item,
	output htpd_pkg::frm_state_t nxt,
	output htpd_pkg::out_item_t res
);
	import htpd_pkg::*;

	logic [16:0] fill_sum;
	logic [7:0] want;
	logic [2:0] ev;
	logic [LenW-1:0] plen;
	frm_state_t st;

	assign fill_sum = {1'b0, item.chunk_length} + 17'(cur.pending_count);

	always_comb begin
		case (cur.header_index[1:0])
			2'd0: want = cfg.header_word[31:24];
			2'd1: want = cfg.header_word[23:16];
			2'd2: want = cfg.header_word[15:8];
			default: want = cfg.header_word[7:0];
		endcase
	end

	always_comb begin
		st = cur;
		ev = EV_DROPPED;
		plen = '0;

		// chunk start and receive buffer overflow
		if (item.chunk_first) begin
			st.dropping_chunk = 1'b0;
			if (fill_sum > 17'(cfg.recv_buffer_limit)) begin
				st.header_index = '0;
				st.header_bad = 1'b0;
				st.pending_count = '0;
				st.dropping_chunk = 1'b1;
				ev = EV_OVERFLOW_ABORT;
			end
		end

		if (ev == EV_DROPPED && !st.dropping_chunk) begin
			if (st.pending_count != SatLen)
				st.pending_count = st.pending_count + 1'b1;
			plen = st.pending_count;
			if (st.header_index < 3'(HdrBytes)) begin
				if (item.in_byte != want)
					st.header_bad = 1'b1;
				st.header_index = st.header_index + 1'b1;
				if (st.header_index == 3'(HdrBytes) && st.header_bad) begin
					ev = EV_HEADER_ABORT;
					st.header_index = '0;
					st.header_bad = 1'b0;
					st.pending_count = '0;
					st.dropping_chunk = 1'b1;
				end else begin
					ev = EV_PACKET_BYTE;
				end
			end else if (item.in_byte == cfg.tail_byte) begin
				ev = (plen < cfg.max_packet_len) ? EV_GOOD_END : EV_TOO_LONG_END;
				st.header_index = '0;
				st.header_bad = 1'b0;
				st.pending_count = '0;
			end else begin
				ev = EV_PACKET_BYTE;
			end
			// chunk ends with an unfinished packet already too long
			if (item.chunk_last && ev == EV_PACKET_BYTE
					&& st.pending_count > cfg.max_packet_len) begin
				ev = EV_OVERLENGTH_ABORT;
				st.header_index = '0;
				st.header_bad = 1'b0;
				st.pending_count = '0;
			end
		end

		if (item.chunk_last)
			st.dropping_chunk = 1'b0;
	end

	assign nxt = st;
	assign res.out_byte = item.in_byte;
	assign res.out_conn_id = item.conn_id;
	assign res.event_res = ev;
	assign res.packet_length = plen;

endmodule

FILE: hw/rtl/header_tail_packet_deframer.sv
// Splits a chunked byte stream into header/tail delimited packets and passes every
// byte through with an event mark, packet length so far and its connection id.
// One byte is taken per clock while the skid entry is empty: the framing state is
// updated at the edge the byte transfers, and the marked byte is registered at that
// same edge, into the output register if it is free, else into the skid entry.
// A second result register keeps the input side open for one more byte while the
// output is stalled, so throughput is one byte per cycle whenever the consumer keeps
// up. Configuration is written through cfg_wr_en/cfg_index/cfg_wdata and must only
// change while no byte is in flight.
module header_tail_packet_deframer (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_wdata,
	input logic item_valid,
	output logic item_ready,
	input htpd_pkg::in_item_t item,
	output logic result_valid,
	input logic result_ready,
	output htpd_pkg::out_item_t result
);
	import htpd_pkg::*;

	cfg_t cfg_q;
	frm_state_t state_q;
	frm_state_t state_nxt;
	out_item_t res_nxt;
	out_item_t out_q;
	out_item_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic in_xfer;
	logic out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_word <= HeaderWordRst;
			cfg_q.tail_byte <= TailByteRst;
			cfg_q.max_packet_len <= MaxPacketLenRst;
			cfg_q.recv_buffer_limit <= RecvBufferLimitRst;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HEADER_WORD: cfg_q.header_word <= cfg_wdata;
				REG_TAIL_BYTE: cfg_q.tail_byte <= cfg_wdata[7:0];
				REG_MAX_PACKET_LEN: cfg_q.max_packet_len <= cfg_wdata[LenW-1:0];
				REG_RECV_BUFFER_LIMIT: cfg_q.recv_buffer_limit <= cfg_wdata[LenW-1:0];
				default: ;
			endcase
		end
	end

	htpd_step u_step (
		.cfg(cfg_q),
		.cur(state_q),
		.item(item),
		.nxt(state_nxt),
		.res(res_nxt)
	);

	assign item_ready = !skid_valid_q;
	assign in_xfer = item_valid && item_ready;
	assign out_free = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_xfer;
				end
			end else if (in_xfer) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (in_xfer)
				out_q <= res_nxt;
		end else if (in_xfer) begin
			skid_q <= res_nxt;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule
